>>> hw/rtl/pcb_pkg.sv
// Package for the particle cell binning block: field widths, function and
// status codes, register indexes and the control struct for the axis units.
// No dependencies; every other file of the block imports it.
package pcb_pkg;

  localparam int MAX_CELLS_DEF      = 4096;
  localparam int SLOTS_PER_CELL_DEF = 16;
  localparam int FRAC_BITS_DEF      = 16;

  localparam int FRAC_W     = 18;
  localparam int SHIFT_W    = 16;
  localparam int CELLS_W    = 13;
  localparam int CAP_W      = 5;
  localparam int PMASK_W    = 3;
  localparam int CELL_IDX_W = 12;
  localparam int SLOT_IDX_W = 4;
  localparam int COUNT_W    = 16;
  localparam int REC_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_BIN   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_INVALID  = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE  = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIODIC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd7;

  // Stage enables for one axis unit.
  typedef struct packed {
    logic load;
    logic bin_en;
  } pcb_axis_ctl_t;

endpackage

>>> hw/rtl/pcb_if.sv
// Valid/ready channel interfaces for the particle cell binning block:
// pcb_in_if carries items in, pcb_out_if carries results out.
// Depends on pcb_pkg for the field widths.
interface pcb_in_if import pcb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               func;
  logic signed [FRAC_W-1:0] frac_x;
  logic signed [FRAC_W-1:0] frac_y;
  logic signed [FRAC_W-1:0] frac_z;
  logic                     pos_invalid;
  logic [CELL_IDX_W-1:0]    read_cell;
  logic [SLOT_IDX_W-1:0]    read_slot;

  modport source (
    output valid, func, frac_x, frac_y, frac_z, pos_invalid, read_cell, read_slot,
    input  ready
  );
  modport sink (
    input  valid, func, frac_x, frac_y, frac_z, pos_invalid, read_cell, read_slot,
    output ready
  );
endinterface

interface pcb_out_if import pcb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CELL_IDX_W-1:0] cell_index;
  logic [COUNT_W-1:0]    slot_offset;
  logic                  stored;
  logic [1:0]            status;
  logic [COUNT_W-1:0]    particle_id;
  logic [REC_W-1:0]      overflow_need;
  logic [REC_W-1:0]      invalid_record;
  logic [REC_W-1:0]      outside_record;

  modport source (
    output valid, cell_index, slot_offset, stored, status, particle_id,
           overflow_need, invalid_record, outside_record,
    input  ready
  );
  modport sink (
    input  valid, cell_index, slot_offset, stored, status, particle_id,
           overflow_need, invalid_record, outside_record,
    output ready
  );
endinterface

>>> hw/rtl/pcb_axis_bin.sv
// One axis of the binning arithmetic: (frac - shift) * cells in a registered
// multiply, then floor, periodic wrap and range check into a registered bin.
// Depends on pcb_pkg.
module pcb_axis_bin import pcb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  pcb_axis_ctl_t             ctl,
  input  logic signed [FRAC_W-1:0]  frac,
  input  logic signed [SHIFT_W-1:0] shift,
  input  logic [CELLS_W-1:0]        cells,
  input  logic                      periodic,
  output logic [CELLS_W-1:0]        bin,
  output logic                      bin_ok
);

  localparam int DIFF_W = FRAC_W + 1;
  localparam int PROD_W = DIFF_W + CELLS_W + 1;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] ncells;
  logic signed [PROD_W-1:0] flr;
  logic signed [PROD_W-1:0] wrapped;
  logic                     ok_nxt;
  logic [CELLS_W-1:0]       bin_r;
  logic                     ok_r;

  assign diff     = DIFF_W'(frac) - DIFF_W'(shift);
  assign ncells   = PROD_W'($signed({1'b0, cells}));
  assign prod_nxt = PROD_W'(diff) * ncells;

  // An arithmetic shift rounds toward minus infinity, which is the floor.
  assign flr = prod_r >>> FRAC_BITS;

  always_comb begin
    wrapped = flr;
    if (periodic) begin
      if (flr == ncells) begin
        wrapped = '0;
      end else if (flr == '1) begin
        wrapped = ncells - PROD_W'(1);
      end
    end
  end

  assign ok_nxt = !wrapped[PROD_W-1] && (wrapped < ncells);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod_r <= prod_nxt;
    end
    if (ctl.bin_en) begin
      bin_r <= CELLS_W'(wrapped);
      ok_r  <= ok_nxt;
    end
  end

  assign bin    = bin_r;
  assign bin_ok = ok_r;

endmodule

>>> hw/rtl/particle_cell_binning_top.sv
// Particle cell binning, top level. Depends on pcb_pkg, pcb_if and pcb_axis_bin.
//
// One item is worked on at a time. A bin item passes through a registered
// multiply per axis, the bin and wrap stage, the two multiplies of the linear
// index, and a read-modify-write of the cell count memory. An item flagged as
// an invalid position and an unused function code go straight to the output
// state, a particle found outside the box leaves after the bin stage or the
// linear index, and a read item after its memory reads; each then waits for
// the output register to be free. After reset, and after every clear item, a
// clearing pass writes zero to each of the MAX_CELLS cell counts, one a cycle,
// and no item is taken during it; the clear item's result follows the pass.
// Configuration writes are taken at any time but must only be made while idle.
module particle_cell_binning_top import pcb_pkg::*; #(
  parameter int MAX_CELLS      = MAX_CELLS_DEF,
  parameter int SLOTS_PER_CELL = SLOTS_PER_CELL_DEF,
  parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pcb_in_if.sink                in_ch,
  pcb_out_if.source             out_ch
);

  localparam int CELL_AW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int SLOT_AW    = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
  localparam int SLOT_DEPTH = MAX_CELLS * (1 << SLOT_AW);
  localparam int INNER_W    = 2 * CELLS_W + 1;
  localparam int LIN_W      = CELLS_W + INNER_W + 1;
  localparam int SLIM_W     = COUNT_W + 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_BIN   = 4'd1;
  localparam logic [3:0] ST_INNER = 4'd2;
  localparam logic [3:0] ST_LIN   = 4'd3;
  localparam logic [3:0] ST_RD    = 4'd4;
  localparam logic [3:0] ST_WB    = 4'd5;
  localparam logic [3:0] ST_RDOUT = 4'd6;
  localparam logic [3:0] ST_OUT   = 4'd7;
  localparam logic [3:0] ST_CLR   = 4'd8;

  localparam logic [SLIM_W-1:0]  SLOTS_LIM  = SLIM_W'(SLOTS_PER_CELL);
  localparam logic [SLIM_W-1:0]  CELLS_LIM  = SLIM_W'(MAX_CELLS);
  localparam logic [LIN_W-1:0]   LIN_LIM    = LIN_W'(MAX_CELLS);
  localparam logic [CELL_AW-1:0] CLR_LAST   = CELL_AW'(MAX_CELLS - 1);

  // Configuration registers.
  logic [CELLS_W-1:0]        cells_x_r, cells_y_r, cells_z_r;
  logic [PMASK_W-1:0]        periodic_r;
  logic signed [SHIFT_W-1:0] shift_x_r, shift_y_r, shift_z_r;
  logic [CAP_W-1:0]          capacity_r;

  // Control and build state.
  logic [3:0]         state_r, state_nxt;
  logic [CELL_AW-1:0] clr_cnt_r;
  logic               clr_res_r;
  logic [COUNT_W-1:0] counter_r;
  logic [REC_W-1:0]   ovf_r, inv_r, outside_r;
  logic [COUNT_W-1:0] id_r;

  // Datapath registers.
  logic [INNER_W-1:0] inner_r;
  logic [CELL_AW-1:0] lin_r;
  logic [CELL_IDX_W-1:0] rd_cell_r;
  logic               rd_cell_ok_r, rd_slot_ok_r;

  // Result waiting for the output register.
  logic [CELL_IDX_W-1:0] res_cidx_r;
  logic [COUNT_W-1:0]    res_offs_r;
  logic                  res_stored_r;
  logic [1:0]            res_status_r;
  logic [COUNT_W-1:0]    res_pid_r;

  // Output register.
  logic                  out_valid_r;
  logic [CELL_IDX_W-1:0] out_cidx_r;
  logic [COUNT_W-1:0]    out_offs_r;
  logic                  out_stored_r;
  logic [1:0]            out_status_r;
  logic [COUNT_W-1:0]    out_pid_r;
  logic [REC_W-1:0]      out_ovf_r, out_inv_r, out_outside_r;

  // Memories.
  logic [COUNT_W-1:0] cnt_mem [MAX_CELLS];
  logic [COUNT_W-1:0] slot_mem [SLOT_DEPTH];
  logic [COUNT_W-1:0] cnt_q;
  logic [COUNT_W-1:0] slot_q;

  logic                       in_acc;
  logic                       out_load;
  pcb_axis_ctl_t              axis_ctl;
  logic [CELLS_W-1:0]         bin_x, bin_y, bin_z;
  logic                       ok_x, ok_y, ok_z, all_ok;
  logic [INNER_W-1:0]         inner_nxt;
  logic [LIN_W-1:0]           lin_full;
  logic                       lin_out;
  logic [SLIM_W-1:0]          cap_ext, cap_eff, cnt_ext, need;
  logic                       cnt_fits;
  logic                       cnt_we, cnt_re;
  logic [CELL_AW-1:0]         cnt_waddr, cnt_raddr;
  logic [COUNT_W-1:0]         cnt_wdata;
  logic                       slot_we, slot_re;
  logic [CELL_AW+SLOT_AW-1:0] slot_waddr, slot_raddr;
  logic                       clr_last;
  logic                       is_read;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_read     = in_acc && (in_ch.func == FUNC_READ);
  assign out_load    = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);
  assign clr_last    = (clr_cnt_r == CLR_LAST);

  // Axis units: the multiply is registered on the transfer itself.
  assign axis_ctl.load   = in_acc;
  assign axis_ctl.bin_en = (state_r == ST_BIN);

  pcb_axis_bin #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk(clk), .ctl(axis_ctl), .frac(in_ch.frac_x), .shift(shift_x_r),
    .cells(cells_x_r), .periodic(periodic_r[0]), .bin(bin_x), .bin_ok(ok_x)
  );
  pcb_axis_bin #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk(clk), .ctl(axis_ctl), .frac(in_ch.frac_y), .shift(shift_y_r),
    .cells(cells_y_r), .periodic(periodic_r[1]), .bin(bin_y), .bin_ok(ok_y)
  );
  pcb_axis_bin #(.FRAC_BITS(FRAC_BITS)) u_axis_z (
    .clk(clk), .ctl(axis_ctl), .frac(in_ch.frac_z), .shift(shift_z_r),
    .cells(cells_z_r), .periodic(periodic_r[2]), .bin(bin_z), .bin_ok(ok_z)
  );

  assign all_ok    = ok_x && ok_y && ok_z;
  assign inner_nxt = INNER_W'(bin_y) + INNER_W'(cells_y_r) * INNER_W'(bin_z);
  assign lin_full  = LIN_W'(bin_x) + LIN_W'(cells_x_r) * LIN_W'(inner_r);
  assign lin_out   = (lin_full >= LIN_LIM);

  assign cap_ext  = SLIM_W'(capacity_r);
  assign cap_eff  = (cap_ext < SLOTS_LIM) ? cap_ext : SLOTS_LIM;
  assign cnt_ext  = SLIM_W'(cnt_q);
  assign cnt_fits = (cnt_ext < cap_eff);
  assign need     = cnt_ext + SLIM_W'(1);

  // Count memory: the clearing pass and the write-back share one write port.
  assign cnt_we    = (state_r == ST_CLR) || ((state_r == ST_WB) && (cnt_q != '1));
  assign cnt_waddr = (state_r == ST_CLR) ? clr_cnt_r : lin_r;
  assign cnt_wdata = (state_r == ST_CLR) ? '0 : cnt_q + COUNT_W'(1);
  assign cnt_re    = is_read || (state_r == ST_RD);
  assign cnt_raddr = (state_r == ST_RD) ? lin_r : CELL_AW'(in_ch.read_cell);

  assign slot_we    = (state_r == ST_WB) && cnt_fits;
  assign slot_waddr = {lin_r, SLOT_AW'(cnt_q)};
  assign slot_re    = is_read;
  assign slot_raddr = {CELL_AW'(in_ch.read_cell), SLOT_AW'(in_ch.read_slot)};

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_q <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= id_r;
    end
    if (slot_re) begin
      slot_q <= slot_mem[slot_raddr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.func)
            FUNC_CLEAR: state_nxt = ST_CLR;
            FUNC_BIN:   state_nxt = in_ch.pos_invalid ? ST_OUT : ST_BIN;
            FUNC_READ:  state_nxt = ST_RDOUT;
            default:    state_nxt = ST_OUT;
          endcase
        end
      end
      ST_BIN:   state_nxt = ST_INNER;
      ST_INNER: state_nxt = all_ok ? ST_LIN : ST_OUT;
      ST_LIN:   state_nxt = lin_out ? ST_OUT : ST_RD;
      ST_RD:    state_nxt = ST_WB;
      ST_WB:    state_nxt = ST_OUT;
      ST_RDOUT: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLR: begin
        if (clr_last) begin
          state_nxt = clr_res_r ? ST_OUT : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state, records and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      clr_res_r   <= 1'b0;
      counter_r   <= '0;
      ovf_r       <= '0;
      inv_r       <= '0;
      outside_r   <= '0;
      out_valid_r <= 1'b0;
      cells_x_r   <= CELLS_W'(16);
      cells_y_r   <= CELLS_W'(16);
      cells_z_r   <= CELLS_W'(16);
      periodic_r  <= '1;
      shift_x_r   <= '0;
      shift_y_r   <= '0;
      shift_z_r   <= '0;
      capacity_r  <= CAP_W'(4);
    end else begin
      state_r <= state_nxt;

      if (state_r == ST_CLR) begin
        clr_cnt_r <= clr_last ? '0 : clr_cnt_r + CELL_AW'(1);
        if (clr_last) begin
          clr_res_r <= 1'b0;
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_CELLS_X:  cells_x_r  <= cfg_data[CELLS_W-1:0];
          REG_CELLS_Y:  cells_y_r  <= cfg_data[CELLS_W-1:0];
          REG_CELLS_Z:  cells_z_r  <= cfg_data[CELLS_W-1:0];
          REG_PERIODIC: periodic_r <= cfg_data[PMASK_W-1:0];
          REG_SHIFT_X:  shift_x_r  <= cfg_data[SHIFT_W-1:0];
          REG_SHIFT_Y:  shift_y_r  <= cfg_data[SHIFT_W-1:0];
          REG_SHIFT_Z:  shift_z_r  <= cfg_data[SHIFT_W-1:0];
          REG_CAPACITY: capacity_r <= cfg_data[CAP_W-1:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        case (in_ch.func)
          FUNC_CLEAR: begin
            counter_r <= '0;
            ovf_r     <= '0;
            inv_r     <= '0;
            outside_r <= '0;
            clr_res_r <= 1'b1;
          end
          FUNC_BIN: begin
            // The counter saturates, so late particles share the last id.
            if (counter_r != '1) begin
              counter_r <= counter_r + COUNT_W'(1);
            end
            if (in_ch.pos_invalid) begin
              inv_r <= REC_W'(counter_r) + REC_W'(1);
            end
          end
          default: ;
        endcase
      end

      if (((state_r == ST_INNER) && !all_ok) || ((state_r == ST_LIN) && lin_out)) begin
        outside_r <= REC_W'(id_r) + REC_W'(1);
      end

      if ((state_r == ST_WB) && !cnt_fits && (need > ovf_r)) begin
        ovf_r <= need;
      end
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      id_r         <= counter_r;
      rd_cell_r    <= in_ch.read_cell;
      rd_cell_ok_r <= (SLIM_W'(in_ch.read_cell) < CELLS_LIM);
      rd_slot_ok_r <= (SLIM_W'(in_ch.read_slot) < SLOTS_LIM);
      res_cidx_r   <= '0;
      res_offs_r   <= '0;
      res_stored_r <= 1'b0;
      res_status_r <= ((in_ch.func == FUNC_BIN) && in_ch.pos_invalid) ?
                      STATUS_INVALID : STATUS_OK;
      res_pid_r    <= (in_ch.func == FUNC_BIN) ? counter_r : '0;
    end

    case (state_r)
      ST_INNER: begin
        inner_r <= inner_nxt;
        if (!all_ok) begin
          res_status_r <= STATUS_OUTSIDE;
        end
      end
      ST_LIN: begin
        lin_r <= CELL_AW'(lin_full);
        if (lin_out) begin
          res_status_r <= STATUS_OUTSIDE;
        end
      end
      ST_WB: begin
        res_cidx_r   <= CELL_IDX_W'(lin_r);
        res_offs_r   <= cnt_q;
        res_stored_r <= cnt_fits;
        res_status_r <= cnt_fits ? STATUS_OK : STATUS_OVERFLOW;
      end
      ST_RDOUT: begin
        res_cidx_r <= rd_cell_r;
        res_offs_r <= rd_cell_ok_r ? cnt_q : '0;
        res_pid_r  <= (rd_cell_ok_r && rd_slot_ok_r) ? slot_q : '0;
      end
      default: ;
    endcase

    if (out_load) begin
      out_cidx_r    <= res_cidx_r;
      out_offs_r    <= res_offs_r;
      out_stored_r  <= res_stored_r;
      out_status_r  <= res_status_r;
      out_pid_r     <= res_pid_r;
      out_ovf_r     <= ovf_r;
      out_inv_r     <= inv_r;
      out_outside_r <= outside_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cell_index     = out_cidx_r;
  assign out_ch.slot_offset    = out_offs_r;
  assign out_ch.stored         = out_stored_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.particle_id    = out_pid_r;
  assign out_ch.overflow_need  = out_ovf_r;
  assign out_ch.invalid_record = out_inv_r;
  assign out_ch.outside_record = out_outside_r;

endmodule
